FILE: sv/v3n_pkg.sv
// Shared types and constants for the vector normalizer.
package v3n_pkg;

    localparam int COMP_W = 32;
    localparam int SUM_W  = 64;
    localparam int MAG_W  = 32;
    localparam int THR_W  = 31;

    // Configuration register byte addresses.
    localparam logic [1:0] ADDR_MIN_MAG = 2'd0;

    typedef logic signed [COMP_W-1:0] comp_t;

endpackage

FILE: sv/v3n_sqrt_stage.sv
// One pipeline stage of the integer square root: resolves two root bits.
module v3n_sqrt_stage #(
    parameter int STEP = 0
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [63:0] in_rem,
    input  logic [31:0] in_root,
    output logic        out_valid,
    output logic [63:0] out_rem,
    output logic [31:0] out_root
);
    // Two digits per stage, restoring method on the remainder.
    localparam int B0 = 31 - 2*STEP;
    localparam int B1 = B0 - 1;

    logic [63:0] rem_a;
    logic [31:0] root_a;
    logic [63:0] trial_a;
    logic [63:0] rem_b;
    logic [31:0] root_b;
    logic [63:0] trial_b;
    logic        valid_reg;
    logic [63:0] rem_reg;
    logic [31:0] root_reg;

    always_comb
    begin
        trial_a = ({32'd0, in_root} << (B0 + 1)) + (64'd1 << (2*B0));
        rem_a   = in_rem;
        root_a  = in_root;
        if (in_rem >= trial_a)
        begin
            rem_a  = in_rem - trial_a;
            root_a = in_root | (32'd1 << B0);
        end
        trial_b = ({32'd0, root_a} << (B1 + 1)) + (64'd1 << (2*B1));
        rem_b   = rem_a;
        root_b  = root_a;
        if (rem_a >= trial_b)
        begin
            rem_b  = rem_a - trial_b;
            root_b = root_a | (32'd1 << B1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_b;
            root_reg <= root_b;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
endmodule

FILE: sv/v3n_div_stage.sv
// One pipeline stage of the restoring divider: two quotient bits per lane.
module v3n_div_stage #(
    parameter int QW = 48
) (
    input  logic          clk,
    input  logic          en,
    input  logic [QW-1:0] in_num,
    input  logic [32:0]   in_rem,
    input  logic [31:0]   divisor,
    output logic [QW-1:0] out_num,
    output logic [32:0]   out_rem
);
    logic [33:0]   r1;
    logic [33:0]   r2;
    logic [32:0]   m1;
    logic [32:0]   m2;
    logic [QW-1:0] n1;
    logic [QW-1:0] n2;
    logic [QW-1:0] num_reg;
    logic [32:0]   rem_reg;

    // Numerator register shifts left; quotient bits fill in at the bottom.
    always_comb
    begin
        r1 = {in_rem, in_num[QW-1]};
        n1 = {in_num[QW-2:0], 1'b0};
        if (r1 >= {2'b00, divisor})
        begin
            m1 = 33'(r1 - {2'b00, divisor});
            n1[0] = 1'b1;
        end
        else
        begin
            m1 = r1[32:0];
        end
        r2 = {m1, n1[QW-1]};
        n2 = {n1[QW-2:0], 1'b0};
        if (r2 >= {2'b00, divisor})
        begin
            m2 = 33'(r2 - {2'b00, divisor});
            n2[0] = 1'b1;
        end
        else
        begin
            m2 = r2[32:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg <= n2;
            rem_reg <= m2;
        end
    end

    assign out_num = num_reg;
    assign out_rem = rem_reg;
endmodule

FILE: sv/vector3_normalize_top.sv
// Top level of the pipelined 3-D vector normalizer.
//
//  channel | signals                                   | role
//  --------+-------------------------------------------+----------------------------
//  in      | in_valid, in_ready, comp_x/y/z            | one vector per transaction
//  out     | out_valid, out_ready, unit_x/y/z, scaled  | one result per transaction
//  cfg     | psel, penable, pwrite, paddr, pwdata ...  | APB write/read of min_magnitude
//
// One vector enters per cycle while the output stage is not stalled. The stages are a squaring
// stage, a sum stage, sixteen square-root stages (two root bits each), a threshold stage,
// the divider stages (two quotient bits each, three lanes side by side) and a sign stage.
// The whole pipeline advances as one when the output stage is empty or being taken, so a
// stall freezes every stage and nothing is lost or repeated. Reset clears all valid bits
// and sets min_magnitude to zero.
module vector3_normalize_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [1:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  v3n_pkg::comp_t        comp_x,
    input  v3n_pkg::comp_t        comp_y,
    input  v3n_pkg::comp_t        comp_z,
    output logic                  out_valid,
    input  logic                  out_ready,
    output v3n_pkg::comp_t        unit_x,
    output v3n_pkg::comp_t        unit_y,
    output v3n_pkg::comp_t        unit_z,
    output logic                  scaled
);
    import v3n_pkg::*;

    // The numerator |c| << FRAC_BITS plus mag/2 fits in QW bits.
    localparam int QW         = 33 + FRAC_BITS + 1;
    localparam int QWE        = QW + (QW % 2);
    localparam int DIV_STAGES = QWE / 2;
    localparam int SQ_STAGES  = 16;
    localparam int NCOMP      = 3;

    logic [THR_W-1:0] min_mag_reg;
    logic             en;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_mag_reg <= '0;
        end
        else if (psel && penable && pwrite && (paddr == ADDR_MIN_MAG))
        begin
            min_mag_reg <= pwdata[THR_W-1:0];
        end
    end
    assign prdata = (paddr == ADDR_MIN_MAG) ? {1'b0, min_mag_reg} : 32'd0;

    // The pipeline moves whenever the output register can take a new value.
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // ---------------- stage 1: absolute values and squares ----------------
    logic             s1_valid_reg;
    comp_t            s1_c_reg [NCOMP];
    logic [SUM_W-1:0] s1_sq_reg [NCOMP];
    comp_t            in_c [NCOMP];
    logic [COMP_W-1:0] in_abs [NCOMP];

    assign in_c[0] = comp_x;
    assign in_c[1] = comp_y;
    assign in_c[2] = comp_z;

    always_comb
    begin
        for (int i = 0; i < NCOMP; i++)
        begin
            in_abs[i] = in_c[i][COMP_W-1] ? COMP_W'(-in_c[i]) : COMP_W'(in_c[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NCOMP; i++)
            begin
                s1_c_reg[i]  <= in_c[i];
                s1_sq_reg[i] <= {32'd0, in_abs[i]} * {32'd0, in_abs[i]};
            end
        end
    end

    // ---------------- stage 2: sum of squares ----------------
    logic             s2_valid_reg;
    comp_t            s2_c_reg [NCOMP];
    logic [SUM_W-1:0] s2_sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_c_reg   <= s1_c_reg;
            s2_sum_reg <= s1_sq_reg[0] + s1_sq_reg[1] + s1_sq_reg[2];
        end
    end

    // ---------------- square root pipeline ----------------
    logic        sq_valid [SQ_STAGES+1];
    logic [63:0] sq_rem   [SQ_STAGES+1];
    logic [31:0] sq_root  [SQ_STAGES+1];
    comp_t       sq_c_reg [SQ_STAGES][NCOMP];

    assign sq_valid[0] = s2_valid_reg;
    assign sq_rem[0]   = s2_sum_reg;
    assign sq_root[0]  = '0;

    for (genvar g = 0; g < SQ_STAGES; g++)
    begin : g_sqrt
        v3n_sqrt_stage #(.STEP(g)) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (sq_valid[g]),
            .in_rem    (sq_rem[g]),
            .in_root   (sq_root[g]),
            .out_valid (sq_valid[g+1]),
            .out_rem   (sq_rem[g+1]),
            .out_root  (sq_root[g+1])
        );
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (g == 0)
                    sq_c_reg[g] <= s2_c_reg;
                else
                    sq_c_reg[g] <= sq_c_reg[g-1];
            end
        end
    end

    logic unused_rem;
    assign unused_rem = ^sq_rem[SQ_STAGES];

    // ---------------- threshold and numerators ----------------
    logic              th_valid_reg;
    logic              th_scale_reg;
    logic [MAG_W-1:0]  th_mag_reg;
    comp_t             th_c_reg   [NCOMP];
    logic [QWE-1:0]    th_num_reg [NCOMP];
    comp_t             sq_c_last  [NCOMP];
    logic [MAG_W-1:0]  mag;

    assign mag       = sq_root[SQ_STAGES];
    assign sq_c_last = sq_c_reg[SQ_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            th_valid_reg <= 1'b0;
        else if (en)
            th_valid_reg <= sq_valid[SQ_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            th_scale_reg <= (mag > {1'b0, min_mag_reg});
            // A zero magnitude divides by one to keep the divider defined.
            th_mag_reg   <= (mag == '0) ? MAG_W'(1) : mag;
            th_c_reg     <= sq_c_last;
            // The absolute value is zero-extended so the most negative input stays positive.
            for (int i = 0; i < NCOMP; i++)
            begin
                th_num_reg[i] <= (QWE'($unsigned(sq_c_last[i][COMP_W-1]
                                    ? COMP_W'(-sq_c_last[i])
                                    : COMP_W'(sq_c_last[i]))) << FRAC_BITS)
                                 + QWE'(mag >> 1);
            end
        end
    end

    // ---------------- divider pipeline ----------------
    logic [QWE-1:0]   dv_num  [DIV_STAGES+1][NCOMP];
    logic [32:0]      dv_rem  [DIV_STAGES+1][NCOMP];
    logic             dv_valid_reg [DIV_STAGES];
    logic             dv_scale_reg [DIV_STAGES];
    logic [MAG_W-1:0] dv_mag_reg   [DIV_STAGES];
    comp_t            dv_c_reg     [DIV_STAGES][NCOMP];
    logic [MAG_W-1:0] dv_mag_in    [DIV_STAGES];

    for (genvar k = 0; k < NCOMP; k++)
    begin : g_lane_in
        assign dv_num[0][k] = th_num_reg[k];
        assign dv_rem[0][k] = '0;
    end

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        assign dv_mag_in[g] = (g == 0) ? th_mag_reg : dv_mag_reg[(g == 0) ? 0 : g-1];
        for (genvar k = 0; k < NCOMP; k++)
        begin : g_lane
            v3n_div_stage #(.QW(QWE)) u_div (
                .clk     (clk),
                .en      (en),
                .in_num  (dv_num[g][k]),
                .in_rem  (dv_rem[g][k]),
                .divisor (dv_mag_in[g]),
                .out_num (dv_num[g+1][k]),
                .out_rem (dv_rem[g+1][k])
            );
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[g] <= 1'b0;
            else if (en)
                dv_valid_reg[g] <= (g == 0) ? th_valid_reg
                                            : dv_valid_reg[(g == 0) ? 0 : g-1];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_mag_reg[g] <= dv_mag_in[g];
                if (g == 0)
                begin
                    dv_scale_reg[g] <= th_scale_reg;
                    dv_c_reg[g]     <= th_c_reg;
                end
                else
                begin
                    dv_scale_reg[g] <= dv_scale_reg[g-1];
                    dv_c_reg[g]     <= dv_c_reg[g-1];
                end
            end
        end
    end

    logic unused_div;
    always_comb
    begin
        unused_div = ^dv_mag_reg[DIV_STAGES-1];
        for (int k = 0; k < NCOMP; k++)
            unused_div = unused_div ^ (^dv_rem[DIV_STAGES][k]);
    end

    // ---------------- output stage: sign and selection ----------------
    logic  out_valid_reg;
    logic  scaled_reg;
    comp_t unit_reg [NCOMP];
    comp_t res_c    [NCOMP];
    comp_t res_q    [NCOMP];

    always_comb
    begin
        for (int k = 0; k < NCOMP; k++)
        begin
            res_c[k] = dv_c_reg[DIV_STAGES-1][k];
            // Quotient never exceeds 2^FRAC_BITS since mag >= |c|.
            res_q[k] = res_c[k][COMP_W-1] ? -comp_t'(dv_num[DIV_STAGES][k][COMP_W-1:0])
                                          : comp_t'(dv_num[DIV_STAGES][k][COMP_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv_valid_reg[DIV_STAGES-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            scaled_reg <= dv_scale_reg[DIV_STAGES-1];
            for (int k = 0; k < NCOMP; k++)
                unit_reg[k] <= dv_scale_reg[DIV_STAGES-1] ? res_q[k] : res_c[k];
        end
    end

    assign out_valid = out_valid_reg;
    assign unit_x    = unit_reg[0];
    assign unit_y    = unit_reg[1];
    assign unit_z    = unit_reg[2];
    assign scaled    = scaled_reg;

    // ---------------- assertions ----------------
    a_ready_tracks_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not follow the output stage");

    a_stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(unit_x) && $stable(scaled)))
        else $error("stalled result changed");

    a_root_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        sq_valid[SQ_STAGES] |-> (mag[31] == 1'b0 || mag <= 32'hDDB3_D742))
        else $error("square root out of range");

    a_empty_pipe_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (en && !dv_valid_reg[DIV_STAGES-1]) |=> !out_valid)
        else $error("result appeared without an item");
endmodule
